// ----- hdl/lkv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Request and response beat types, request codes and fixed field widths.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 5;
    localparam int CAP_BITS   = 5;

    localparam logic [1:0] REQ_GET = 2'd0;
    localparam logic [1:0] REQ_PUT = 2'd1;
    localparam logic [1:0] REQ_DEL = 2'd2;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [KEY_BITS-1:0]   lookup_key;
        logic [VALUE_BITS-1:0] put_value;
    } t_req;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  released_valid;
        logic [KEY_BITS-1:0]   released_key;
        logic [VALUE_BITS-1:0] released_value;
        logic [COUNT_BITS-1:0] entry_count;
    } t_rsp;

endpackage
`default_nettype wire

// ----- hdl/lru_key_value_cache_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least recently used replacement.
// ----------------------------------------------------------------------------
// Each request beat (get, put or delete) is captured in an input register,
// matched against all entries in parallel, and its result is written to a
// response register in the same cycle as the entry array update. A request
// beat waits in the input register until its result can be written, and one
// request is taken every cycle for as long as the response side keeps up;
// the single pass through the key match and age update sets that figure.
// The capacity register at byte address 0 limits the number of live entries,
// with zero acting as one and values above ENTRIES acting as ENTRIES.
module lru_key_value_cache_unit
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    output logic             o_req_ready,
    input  wire t_req        i_req,
    output logic             o_rsp_valid,
    input  wire logic        i_rsp_ready,
    output t_rsp             o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic                r_req_vld;
    t_req                r_req;
    logic                r_rsp_vld;
    t_rsp                r_rsp;
    t_rsp                w_rsp;
    logic                w_advance;
    logic [CAP_BITS-1:0] w_capacity;

    assign w_advance   = r_req_vld && (!r_rsp_vld || i_rsp_ready);
    assign o_req_ready = !r_req_vld || w_advance;

    lkv_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (w_capacity)
    );

    lkv_core #(
        .ENTRIES (ENTRIES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_advance),
        .i_req      (r_req),
        .i_capacity (w_capacity),
        .o_rsp      (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_req_vld <= i_req_valid;
            end
            if (w_advance) begin
                r_rsp_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_req <= i_req;
        end
        if (w_advance) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

endmodule
`default_nettype wire

// ----- hdl/lkv_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache configuration registers
// APB-style register file holding the capacity register at byte address 0.
// ----------------------------------------------------------------------------
module lkv_cfg
    import lkv_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output logic      [CAP_BITS-1:0] o_capacity
);

    logic [CAP_BITS-1:0] r_capacity;
    logic                w_write;

    assign pready  = 1'b1;
    // Bit 2 of the address selects past the single register.
    assign w_write = psel && penable && pwrite && (paddr[2] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (w_write) begin
            r_capacity <= pwdata[CAP_BITS-1:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == 1'b0) begin
            prdata = {{(32-CAP_BITS){1'b0}}, r_capacity};
        end
    end

    assign o_capacity = r_capacity;

endmodule
`default_nettype wire

// ----- hdl/lkv_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache entry array
// Parallel key match, age bookkeeping and registered state update.
// ----------------------------------------------------------------------------
module lkv_core
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire t_req                i_req,
    input  wire logic [CAP_BITS-1:0] i_capacity,
    output t_rsp                     o_rsp
);

    localparam int AGE_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    logic [ENTRIES-1:0]    r_vld, n_vld;
    logic [KEY_BITS-1:0]   r_key [ENTRIES];
    logic [KEY_BITS-1:0]   n_key [ENTRIES];
    logic [VALUE_BITS-1:0] r_val [ENTRIES];
    logic [VALUE_BITS-1:0] n_val [ENTRIES];
    logic [AGE_BITS-1:0]   r_age [ENTRIES];
    logic [AGE_BITS-1:0]   n_age [ENTRIES];
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;

    logic [ENTRIES-1:0]    w_match, w_found_oh, w_old_oh, w_free, w_slot_oh;
    logic                  w_found;
    logic [AGE_BITS-1:0]   w_found_age, w_last_age;
    logic [KEY_BITS-1:0]   w_found_key, w_old_key;
    logic [VALUE_BITS-1:0] w_found_val, w_old_val;
    logic [CMP_BITS-1:0]   w_cap, w_cap_eff, w_ents;
    logic                  w_evict;

    always_comb begin
        w_cap     = CMP_BITS'(i_capacity);
        w_ents    = CMP_BITS'(ENTRIES);
        w_cap_eff = (w_cap > w_ents) ? w_ents : w_cap;
        if (w_cap == '0) begin
            w_cap_eff = CMP_BITS'(1);
        end
        w_evict    = CMP_BITS'(r_cnt) >= w_cap_eff;
        w_last_age = AGE_BITS'(r_cnt - CNT_BITS'(1));
    end

    // Lookup: lowest matching entry, the oldest entry and the first free slot.
    always_comb begin
        w_found_age = '0;
        w_found_key = '0;
        w_found_val = '0;
        w_old_key   = '0;
        w_old_val   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i]  = r_vld[i] && (r_key[i] == i_req.lookup_key);
            // Valid ages run from zero to count minus one, so the oldest is unique.
            w_old_oh[i] = r_vld[i] && (r_age[i] == w_last_age);
        end
        w_found_oh = w_match & (~w_match + ENTRIES'(1));
        w_found    = |w_match;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_found_oh[i]) begin
                w_found_age = w_found_age | r_age[i];
                w_found_key = w_found_key | r_key[i];
                w_found_val = w_found_val | r_val[i];
            end
            if (w_old_oh[i]) begin
                w_old_key = w_old_key | r_key[i];
                w_old_val = w_old_val | r_val[i];
            end
        end
        w_free    = ~r_vld | (w_evict ? w_old_oh : '0);
        w_slot_oh = w_free & (~w_free + ENTRIES'(1));
    end

    always_comb begin
        n_vld = r_vld;
        n_cnt = r_cnt;
        for (int i = 0; i < ENTRIES; i++) begin
            n_key[i] = r_key[i];
            n_val[i] = r_val[i];
            n_age[i] = r_age[i];
        end
        o_rsp             = '0;
        o_rsp.entry_count = COUNT_BITS'(r_cnt);

        case (i_req.req_type)
            REQ_GET: begin
                if (w_found) begin
                    o_rsp.hit        = 1'b1;
                    o_rsp.read_value = w_found_val;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (w_found_oh[i]) begin
                            n_age[i] = '0;
                        end else if (r_vld[i] && (r_age[i] < w_found_age)) begin
                            n_age[i] = r_age[i] + AGE_BITS'(1);
                        end
                    end
                end
            end
            REQ_PUT: begin
                if (w_found) begin
                    o_rsp.hit            = 1'b1;
                    o_rsp.released_valid = 1'b1;
                    o_rsp.released_key   = w_found_key;
                    o_rsp.released_value = w_found_val;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (w_found_oh[i]) begin
                            n_age[i] = '0;
                            n_val[i] = i_req.put_value;
                        end else if (r_vld[i] && (r_age[i] < w_found_age)) begin
                            n_age[i] = r_age[i] + AGE_BITS'(1);
                        end
                    end
                end else begin
                    if (w_evict) begin
                        o_rsp.released_valid = 1'b1;
                        o_rsp.released_key   = w_old_key;
                        o_rsp.released_value = w_old_val;
                    end else begin
                        n_cnt = r_cnt + CNT_BITS'(1);
                    end
                    // The evicted entry is the oldest, so no other age drops;
                    // every survivor ages by one behind the new entry.
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (w_slot_oh[i]) begin
                            n_vld[i] = 1'b1;
                            n_key[i] = i_req.lookup_key;
                            n_val[i] = i_req.put_value;
                            n_age[i] = '0;
                        end else if (w_evict && w_old_oh[i]) begin
                            n_vld[i] = 1'b0;
                            n_age[i] = '0;
                        end else if (r_vld[i]) begin
                            n_age[i] = r_age[i] + AGE_BITS'(1);
                        end
                    end
                end
                o_rsp.entry_count = COUNT_BITS'(n_cnt);
            end
            REQ_DEL: begin
                if (w_found) begin
                    o_rsp.hit            = 1'b1;
                    o_rsp.released_valid = 1'b1;
                    o_rsp.released_key   = w_found_key;
                    o_rsp.released_value = w_found_val;
                    n_cnt                = r_cnt - CNT_BITS'(1);
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (w_found_oh[i]) begin
                            n_vld[i] = 1'b0;
                            n_age[i] = '0;
                        end else if (r_vld[i] && (r_age[i] > w_found_age)) begin
                            n_age[i] = r_age[i] - AGE_BITS'(1);
                        end
                    end
                end
                o_rsp.entry_count = COUNT_BITS'(n_cnt);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else if (i_fire) begin
            r_vld <= n_vld;
            r_cnt <= n_cnt;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= n_age[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_key[i] <= n_key[i];
                r_val[i] <= n_val[i];
            end
        end
    end

endmodule
`default_nettype wire
